>>> hdl/ssr_pkg.sv
// Shared types and constants for the stream substring replace block.
package ssr_pkg;

  localparam int unsigned SEARCH_REG_BYTES  = 16;
  localparam int unsigned REPLACE_REG_BYTES = 32;
  localparam int unsigned MAX_REPLACE       = 32;
  localparam int unsigned SLEN_W            = 5;
  localparam int unsigned RLEN_W            = 6;
  localparam int unsigned APB_ADDR_W        = 6;
  localparam int unsigned APB_DATA_W        = 64;
  localparam int unsigned Q_DEPTH           = 2;
  localparam int unsigned Q_PTR_W           = 1;
  localparam int unsigned Q_CNT_W           = 2;

  typedef enum logic [2:0] {
    REG_SEARCH_LO,
    REG_SEARCH_HI,
    REG_SEARCH_LEN,
    REG_REPL_A,
    REG_REPL_B,
    REG_REPL_C,
    REG_REPL_D,
    REG_REPL_LEN
  } reg_idx_e;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] text_byte;
    logic       is_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } res_t;

  typedef struct packed {
    logic [SEARCH_REG_BYTES-1:0][7:0]  search;
    logic [REPLACE_REG_BYTES-1:0][7:0] replace;
    logic [SLEN_W-1:0]                 slen;
    logic [RLEN_W-1:0]                 rlen;
    logic                              flush;
  } cfg_t;

endpackage

>>> hdl/ssr_if.sv
// Valid/ready stream interfaces for the input text and the result stream.
interface ssr_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] text_byte;
  logic       is_end;

  modport source (output valid, has_byte, text_byte, is_end, input ready);
  modport sink   (input valid, has_byte, text_byte, is_end, output ready);
endinterface

interface ssr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, out_byte, out_valid, out_last, input ready);
  modport sink   (input valid, out_byte, out_valid, out_last, output ready);
endinterface

>>> hdl/ssr_cfg.sv
// APB register file holding the search and replacement words and lengths.
module ssr_cfg #(
  parameter int unsigned MaxSearch = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ssr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ssr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ssr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output ssr_pkg::cfg_t                    cfg_o
);
  import ssr_pkg::*;

  localparam int unsigned SCap =
      (MaxSearch < SEARCH_REG_BYTES) ? MaxSearch : SEARCH_REG_BYTES;
  localparam int unsigned RCap =
      (MAX_REPLACE < REPLACE_REG_BYTES) ? MAX_REPLACE : REPLACE_REG_BYTES;
  localparam logic [SLEN_W-1:0] SCapL = SLEN_W'(SCap);
  localparam logic [RLEN_W-1:0] RCapL = RLEN_W'(RCap);

  logic [63:0]       search_lo_q, search_hi_q;
  logic [63:0]       repl_a_q, repl_b_q, repl_c_q, repl_d_q;
  logic [SLEN_W-1:0] slen_q;
  logic [RLEN_W-1:0] rlen_q;
  logic              wr;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_lo_q <= '0;
      search_hi_q <= '0;
      slen_q      <= SLEN_W'(1);
      repl_a_q    <= '0;
      repl_b_q    <= '0;
      repl_c_q    <= '0;
      repl_d_q    <= '0;
      rlen_q      <= '0;
    end else if (wr) begin
      case (idx)
        REG_SEARCH_LO:  search_lo_q <= pwdata;
        REG_SEARCH_HI:  search_hi_q <= pwdata;
        REG_SEARCH_LEN: slen_q      <= pwdata[SLEN_W-1:0];
        REG_REPL_A:     repl_a_q    <= pwdata;
        REG_REPL_B:     repl_b_q    <= pwdata;
        REG_REPL_C:     repl_c_q    <= pwdata;
        REG_REPL_D:     repl_d_q    <= pwdata;
        REG_REPL_LEN:   rlen_q      <= pwdata[RLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEARCH_LO:  prdata = search_lo_q;
      REG_SEARCH_HI:  prdata = search_hi_q;
      REG_SEARCH_LEN: prdata = {{(APB_DATA_W-SLEN_W){1'b0}}, slen_q};
      REG_REPL_A:     prdata = repl_a_q;
      REG_REPL_B:     prdata = repl_b_q;
      REG_REPL_C:     prdata = repl_c_q;
      REG_REPL_D:     prdata = repl_d_q;
      REG_REPL_LEN:   prdata = {{(APB_DATA_W-RLEN_W){1'b0}}, rlen_q};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.search  = {search_hi_q, search_lo_q};
    cfg_o.replace = {repl_d_q, repl_c_q, repl_b_q, repl_a_q};
    if (slen_q == '0) begin
      cfg_o.slen = SLEN_W'(1);
    end else if (slen_q > SCapL) begin
      cfg_o.slen = SCapL;
    end else begin
      cfg_o.slen = slen_q;
    end
    cfg_o.rlen  = (rlen_q > RCapL) ? RCapL : rlen_q;
    // pending bytes were matched against the old word
    cfg_o.flush = wr && (idx == REG_SEARCH_LO || idx == REG_SEARCH_HI ||
                         idx == REG_SEARCH_LEN);
  end

endmodule

>>> hdl/ssr_front.sv
// Input side: takes transfers, drops empty items, queues the rest.
module ssr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  ssr_in_if.sink         in_if,
  output logic           q_valid_o,
  output ssr_pkg::item_t q_item_o,
  input  logic           q_pop_i
);
  import ssr_pkg::*;

  item_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_q, rp_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               push, pop;
  item_t              in_item;

  assign in_if.ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
  assign in_item     = '{has_byte: in_if.has_byte, text_byte: in_if.text_byte,
                         is_end: in_if.is_end};
  // an item with neither byte nor end has no effect at all
  assign push        = in_if.valid && in_if.ready && (in_if.has_byte || in_if.is_end);
  assign pop         = q_pop_i && q_valid_o;
  assign q_valid_o   = (cnt_q != '0);
  assign q_item_o    = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item;
  end

endmodule

>>> hdl/ssr_back.sv
// Match sequencer: pending buffer, replacement burst, flush and result stage.
module ssr_back #(
  parameter int unsigned Depth = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  ssr_pkg::item_t q_item_i,
  output logic           q_pop_o,
  input  ssr_pkg::cfg_t  cfg_i,
  ssr_out_if.source      out_if
);
  import ssr_pkg::*;

  localparam logic [SLEN_W-1:0] DepthL = SLEN_W'(Depth);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REPL, S_FLUSH} state_e;

  state_e                state_q, state_d;
  logic [Depth-1:0][7:0] pend_q, pend_d, pend_shift;
  logic [SLEN_W-1:0]     cnt_q, cnt_d;
  logic [RLEN_W-1:0]     ridx_q, ridx_d;
  logic                  end_q, end_d;
  logic                  hold_v_q, hold_v_d;
  logic [7:0]            hold_q, hold_d;
  logic                  out_v_q, out_v_d;
  res_t                  out_q, out_d;
  logic [Depth-1:0]      ok;
  logic                  prefix_ok, out_free, can_emit, emit, finish;
  logic [7:0]            emit_byte;

  assign out_free = !out_v_q || out_if.ready;
  assign can_emit = !hold_v_q || out_free;

  // pending entry k agrees with search byte k, or lies beyond the count
  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      ok[k] = (SLEN_W'(k) >= cnt_q) || (pend_q[k] == cfg_i.search[k]);
    end
    prefix_ok = &ok;
    pend_shift = pend_q;
    for (int k = 0; k < Depth - 1; k++) begin
      pend_shift[k] = pend_q[k+1];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    ridx_d    = ridx_q;
    end_d     = end_q;
    hold_v_d  = hold_v_q;
    hold_d    = hold_q;
    out_v_d   = out_v_q && !out_if.ready;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_byte = pend_q[0];
    finish    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          end_d   = q_item_i.is_end;
          if (q_item_i.has_byte) begin
            if (cnt_q < DepthL) begin
              for (int k = 0; k < Depth; k++) begin
                if (SLEN_W'(k) == cnt_q) pend_d[k] = q_item_i.text_byte;
              end
              cnt_d = cnt_q + 1'b1;
            end
            state_d = S_SCAN;
          end else begin
            state_d = S_FLUSH;
          end
        end
      end
      S_SCAN: begin
        if (cnt_q == '0 || (prefix_ok && cnt_q < cfg_i.slen)) begin
          if (end_q) state_d = S_FLUSH;
          else       finish  = 1'b1;
        end else if (prefix_ok) begin
          // full match: drop the word, emit the replacement
          if (cfg_i.rlen == '0) begin
            cnt_d = '0;
          end else begin
            ridx_d  = '0;
            state_d = S_REPL;
          end
        end else begin
          emit = 1'b1;
          if (can_emit) begin
            pend_d = pend_shift;
            cnt_d  = cnt_q - 1'b1;
          end
        end
      end
      S_REPL: begin
        emit      = 1'b1;
        emit_byte = cfg_i.replace[ridx_q[4:0]];
        if (can_emit) begin
          if (ridx_q == cfg_i.rlen - 1'b1) begin
            cnt_d   = '0;
            state_d = S_SCAN;
          end else begin
            ridx_d = ridx_q + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (cnt_q != '0) begin
          emit = 1'b1;
          if (can_emit) begin
            pend_d = pend_shift;
            cnt_d  = cnt_q - 1'b1;
          end
        end else begin
          finish = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // newest result waits in hold until we know whether it closes the string
    if (emit && can_emit) begin
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = res_t'{out_byte: hold_q, out_valid: 1'b1, out_last: 1'b0};
      end
      hold_d   = emit_byte;
      hold_v_d = 1'b1;
    end

    if (finish) begin
      if (hold_v_q || end_q) begin
        if (out_free) begin
          out_v_d  = 1'b1;
          out_d    = hold_v_q ?
                     res_t'{out_byte: hold_q, out_valid: 1'b1, out_last: end_q} :
                     res_t'{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
          hold_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end else begin
        state_d = S_IDLE;
      end
    end

    if (cfg_i.flush) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ridx_q   <= '0;
      end_q    <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      out_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ridx_q   <= ridx_d;
      end_q    <= end_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
      out_q    <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    hold_q <= hold_d;
  end

  assign out_if.valid     = out_v_q;
  assign out_if.out_byte  = out_q.out_byte;
  assign out_if.out_valid = out_q.out_valid;
  assign out_if.out_last  = out_q.out_last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthL)
    else $error("pending count beyond buffer depth");

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.out_valid |-> out_q.out_last)
    else $error("bare result without last");

  a_hold_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_v_q)
    else $error("held result left over between items");

  a_pop_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE && q_valid_i)
    else $error("queue popped while busy");

endmodule

>>> hdl/stream_substring_replace.sv
// Streaming find-and-replace: top level with APB registers and stream ports.
// Path: a passed-through byte goes from the input queue through the pending buffer
//   and the hold and output registers; a byte held as a possible match start leaves
//   only when the match fails or at end. Flow: the two-entry front queue takes items
//   while the single match/emit sequencer in ssr_back works through one at a time,
//   popping the next only from idle; output stalls hold the sequencer.
// Reset: rst_ni is asynchronous, active low; clears queue, sequencer and pending
//   count, loads search length 1 and all other config registers with 0. No clearing pass.
module stream_substring_replace #(
  parameter int unsigned MAX_SEARCH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ssr_in_if.sink                         in_if,
  ssr_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ssr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ssr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ssr_pkg::*;

  // pending buffer never holds more than a search word's worth of bytes
  localparam int unsigned Depth =
      (MAX_SEARCH < SEARCH_REG_BYTES) ? MAX_SEARCH : SEARCH_REG_BYTES;

  cfg_t  cfg;
  logic  q_valid, q_pop;
  item_t q_item;

  // register file; a search-word or search-length write also empties the pending buffer
  ssr_cfg #(.MaxSearch(MAX_SEARCH)) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: takes input transfers into a two-entry queue so up to two items
  // can wait while the sequencer works through a burst
  ssr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // back: compares, emits replacement or passthrough bytes, flushes at end;
  // its output register lets the next step run while a result waits
  ssr_back #(.Depth(Depth)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg),
    .out_if    (out_if)
  );

endmodule

>>> sim/ssr_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the find-and-replace stream: mirrors its state, queues and checks results.
package ssr_tb_pkg;
  import ssr_pkg::*;

  class replace_scoreboard;
    logic [SEARCH_REG_BYTES-1:0][7:0]  search_word;
    logic [REPLACE_REG_BYTES-1:0][7:0] replace_word;
    logic [SLEN_W-1:0]                 search_len;
    logic [RLEN_W-1:0]                 replace_len;
    logic [7:0]                        held[$];
    res_t                              expected_bytes[$];
    int unsigned                       search_cap;
    int unsigned                       errors;
    int unsigned                       n_items;
    int unsigned                       n_results;
    int unsigned                       n_matches;

    function new(int unsigned max_search);
      search_cap   = (max_search < SEARCH_REG_BYTES) ? max_search : SEARCH_REG_BYTES;
      search_word  = '0;
      replace_word = '0;
      search_len   = SLEN_W'(1);
      replace_len  = '0;
      errors       = 0;
      n_items      = 0;
      n_results    = 0;
      n_matches    = 0;
    endfunction

    // Search register writes drop held bytes: they were tested against the old word.
    function void write_reg(reg_idx_e idx, logic [63:0] value);
      case (idx)
        REG_SEARCH_LO: begin
          search_word[7:0] = value;
          held.delete();
        end
        REG_SEARCH_HI: begin
          search_word[15:8] = value;
          held.delete();
        end
        REG_SEARCH_LEN: begin
          search_len = value[SLEN_W-1:0];
          held.delete();
        end
        REG_REPL_A:   replace_word[7:0]   = value;
        REG_REPL_B:   replace_word[15:8]  = value;
        REG_REPL_C:   replace_word[23:16] = value;
        REG_REPL_D:   replace_word[31:24] = value;
        REG_REPL_LEN: replace_len = value[RLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned word_len();
      int unsigned n;
      n = search_len;
      if (n == 0) n = 1;
      if (n > search_cap) n = search_cap;
      return n;
    endfunction

    function int unsigned subst_len();
      int unsigned n;
      n = replace_len;
      if (n > MAX_REPLACE) n = MAX_REPLACE;
      return n;
    endfunction

    function bit held_prefix_ok(int unsigned n);
      for (int k = 0; k < n; k++)
        if (held[k] != search_word[k]) return 1'b0;
      return 1'b1;
    endfunction

    function void push_byte(logic [7:0] b, logic valid);
      res_t r;
      r.out_byte  = valid ? b : 8'h00;
      r.out_valid = valid;
      r.out_last  = 1'b0;
      expected_bytes.push_back(r);
    endfunction

    // Called on every input transfer; appends the bytes this item releases.
    function void note_input(item_t it);
      int unsigned first;
      int unsigned slen;
      first = expected_bytes.size();
      slen  = word_len();
      n_items++;
      if (it.has_byte && held.size() < search_cap) begin
        held.push_back(it.text_byte);
        while (held.size() > 0) begin
          if (held.size() >= slen) begin
            if (held_prefix_ok(slen)) begin
              for (int k = 0; k < subst_len(); k++) push_byte(replace_word[k], 1'b1);
              repeat (slen) void'(held.pop_front());
              n_matches++;
              continue;
            end
          end else if (held_prefix_ok(held.size())) begin
            break;
          end
          push_byte(held.pop_front(), 1'b1);
        end
      end
      if (it.is_end) begin
        foreach (held[k]) push_byte(held[k], 1'b1);
        held.delete();
        if (expected_bytes.size() == first) push_byte(8'h00, 1'b0);
        expected_bytes[expected_bytes.size()-1].out_last = 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(res_t got);
      res_t want;
      n_results++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected (byte %h valid %b last %b)",
                                  n_results, got.out_byte, got.out_valid, got.out_last));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("result %0d out_byte %h, expected %h",
                                  n_results, got.out_byte, want.out_byte));
      if (got.out_valid !== want.out_valid)
        report_mismatch($sformatf("result %0d out_valid %b, expected %b",
                                  n_results, got.out_valid, want.out_valid));
      if (got.out_last !== want.out_last)
        report_mismatch($sformatf("result %0d out_last %b, expected %b",
                                  n_results, got.out_last, want.out_last));
    endtask

    function int unsigned outstanding();
      return expected_bytes.size();
    endfunction
  endclass

endpackage

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for stream_substring_replace: directed and random text streams.
module testbench;
  import ssr_pkg::*;
  import ssr_tb_pkg::*;

  localparam int unsigned MAX_SEARCH    = 16;
  localparam int unsigned HOLD_CYCLES   = 300;  // long receiver stall, fills the block
  localparam int unsigned SETTLE_CYCLES = 20;   // extra quiet time once no result is outstanding
  localparam int unsigned PHASE_ITEMS   = 50;

  // All block inputs come from 2-state variables, so they are known from time zero.
  bit                  clk_i;
  bit                  rst_ni;
  bit                  tx_valid;
  bit                  tx_has_byte;
  bit [7:0]            tx_text_byte;
  bit                  tx_is_end;
  bit                  rx_ready;
  bit                  psel;
  bit                  penable;
  bit                  pwrite;
  bit [APB_ADDR_W-1:0] paddr;
  bit [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ssr_in_if  in_if ();
  ssr_out_if out_if ();

  assign in_if.valid     = tx_valid;
  assign in_if.has_byte  = tx_has_byte;
  assign in_if.text_byte = tx_text_byte;
  assign in_if.is_end    = tx_is_end;
  assign out_if.ready    = rx_ready;

  stream_substring_replace #(
    .MAX_SEARCH(MAX_SEARCH)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  replace_scoreboard sb = new(MAX_SEARCH);

  // Idle rates in percent, set per phase by the stimulus.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Long-stall handshake between stimulus and receiver: stimulus bumps the
  // request count, the receiver counts the stall out on its own.
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned hold_left;

  // Generator copy of the current search word, plus the small letter set that
  // strings are built from, so that full and partial matches are common.
  logic [7:0]  word[SEARCH_REG_BYTES];
  int unsigned gen_word_len;
  logic [7:0]  alphabet[3];
  int unsigned phase_items;
  int unsigned n_strings;
  int unsigned n_settings;

  always #5 clk_i = ~clk_i;

  // Receiver: check each result transfer, then pick ready for the next cycle.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_if.valid === 1'b1 && rx_ready) begin
      got.out_byte  = out_if.out_byte;
      got.out_valid = out_if.out_valid;
      got.out_last  = out_if.out_last;
      sb.check_result(got);
    end
    if (hold_left == 0 && holds_done != hold_requests) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // All driving tasks are entered right after a rising edge and return right
  // after one, so back-to-back transfers never drive a signal twice per step.

  // APB write: setup, access (register written at the end of it), then a quiet
  // gap so the next setup never lands in the same step as the release.
  task automatic apb_write(reg_idx_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Offer one item after a random gap and wait for its transfer.
  task automatic send_item(logic has_byte, logic [7:0] b, logic is_end);
    item_t it;
    it.has_byte  = has_byte;
    it.text_byte = b;
    it.is_end    = is_end;
    while ($urandom_range(99) < tx_idle_pct) begin
      tx_valid <= 1'b0;
      @(posedge clk_i);
    end
    tx_valid     <= 1'b1;
    tx_has_byte  <= has_byte;
    tx_text_byte <= b;
    tx_is_end    <= is_end;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_input(it);
  endtask

  // Directed text; the end goes on the last byte, on its own item, or nowhere.
  task automatic send_text(string s, bit end_on_byte, bit end_item);
    for (int k = 0; k < s.len(); k++)
      send_item(1'b1, s[k], end_on_byte && (k == s.len() - 1));
    if (end_item) send_item(1'b0, 8'h00, 1'b1);
  endtask

  // Drop valid, wait until every expected byte is back, then let the block go
  // quiet; held bytes make no results, so the extra cycles cover them.
  task automatic settle();
    tx_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // New search/replace setting. Length codes go in raw, with junk in the upper
  // bits, so zero and oversized lengths hit the saturation paths.
  task automatic configure(int unsigned slen_code, int unsigned rlen_code);
    logic [SEARCH_REG_BYTES-1:0][7:0]  sw;
    logic [REPLACE_REG_BYTES-1:0][7:0] rw;
    logic [63:0]                       len_word;
    foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(255, 1));
    gen_word_len = (slen_code == 0) ? 1 : (slen_code > MAX_SEARCH ? MAX_SEARCH : slen_code);
    for (int k = 0; k < SEARCH_REG_BYTES; k++) begin
      // bytes past the length are unused, so they get arbitrary values
      sw[k] = (k < gen_word_len) ? alphabet[$urandom_range(2)] : 8'($urandom);
      word[k] = sw[k];
    end
    for (int k = 0; k < REPLACE_REG_BYTES; k++) rw[k] = 8'($urandom);
    apb_write(REG_SEARCH_LO, sw[7:0]);
    apb_write(REG_SEARCH_HI, sw[15:8]);
    len_word = {$urandom, $urandom};
    len_word[SLEN_W-1:0] = SLEN_W'(slen_code);
    apb_write(REG_SEARCH_LEN, len_word);
    apb_write(REG_REPL_A, rw[7:0]);
    apb_write(REG_REPL_B, rw[15:8]);
    apb_write(REG_REPL_C, rw[23:16]);
    apb_write(REG_REPL_D, rw[31:24]);
    len_word = {$urandom, $urandom};
    len_word[RLEN_W-1:0] = RLEN_W'(rlen_code);
    apb_write(REG_REPL_LEN, len_word);
    n_settings++;
  endtask

  // One random string: mostly whole words and word prefixes, some stray letters
  // and arbitrary bytes, with the odd item that carries neither byte nor end.
  task automatic send_string(int unsigned max_len);
    logic [7:0]  text[$];
    int unsigned target;
    int unsigned cut;
    bit          end_on_byte;
    target = $urandom_range(max_len, 0);
    while (text.size() < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3: for (int k = 0; k < gen_word_len; k++) text.push_back(word[k]);
        4, 5, 6: begin
          cut = $urandom_range(gen_word_len, 1);
          for (int k = 0; k < cut; k++) text.push_back(word[k]);
        end
        7, 8:    text.push_back(alphabet[$urandom_range(2)]);
        default: text.push_back(8'($urandom_range(255, 1)));
      endcase
    end
    end_on_byte = (text.size() > 0) && ($urandom_range(1) == 1);
    foreach (text[k]) begin
      if ($urandom_range(19) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, text[k], end_on_byte && (k == text.size() - 1));
      phase_items++;
    end
    if (!end_on_byte) begin
      send_item(1'b0, 8'($urandom), 1'b1);
      phase_items++;
    end
    n_strings++;
  endtask

  task automatic run_phase(int unsigned slen_code, int unsigned rlen_code,
                           int unsigned tx_pct, int unsigned rx_pct, bit long_hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    configure(slen_code, rlen_code);
    if (long_hold) hold_requests++;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) send_string(3 * gen_word_len + 6);
    settle();
  endtask

  initial begin
    tx_idle_pct = 9;
    rx_idle_pct = 50;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: search word is a single NUL, replacement is empty.
    send_item(1'b1, 8'h00, 1'b0);  // NUL matches and is deleted
    send_item(1'b1, 8'h01, 1'b0);
    send_item(1'b0, 8'hFF, 1'b0);  // neither byte nor end: ignored
    send_item(1'b1, 8'hFF, 1'b1);
    send_item(1'b0, 8'h00, 1'b1);  // end with nothing to emit: bare marker
    settle();

    // "aba" -> "XY": overlap, rescan after mismatch, flush at end.
    apb_write(REG_SEARCH_LO, 64'h0000_0000_0061_6261);
    apb_write(REG_SEARCH_HI, '1);
    apb_write(REG_SEARCH_LEN, 64'd3);
    apb_write(REG_REPL_A, 64'h0000_0000_0000_5958);
    apb_write(REG_REPL_LEN, 64'd2);
    send_text("ababac", 1'b1, 1'b0);
    send_text("aab", 1'b0, 1'b1);
    send_text("abab", 1'b0, 1'b1);
    // Leave a partial match held; the next search write must discard it.
    send_text("ab", 1'b0, 1'b0);
    settle();
    n_settings = 2;

    run_phase(0, 32, 9, 50, 1'b0);   // length code 0 acts as 1, longest replacement
    run_phase(3, 8, 9, 50, 1'b1);    // receiver stalls long while items keep coming
    run_phase(16, 0, 50, 9, 1'b0);   // longest search word, matches deleted
    run_phase(31, 63, 50, 9, 1'b0);  // oversized lengths saturate
    run_phase($urandom_range(6, 2), $urandom_range(12), 0, 0, 1'b0);
    run_phase($urandom_range(31), $urandom_range(63), 0, 0, 1'b0);

    $display("Covered %0d input transfers in %0d strings over %0d register settings.",
             sb.n_items, n_strings, n_settings);
    $display("Checked %0d result transfers with %0d full matches replaced; %0d mismatches.",
             sb.n_results, sb.n_matches, sb.errors);
    if (sb.errors == 0) begin
      $display("** stream_substring_replace: PASSED **");
    end else begin
      $display("** stream_substring_replace: FAILED **");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still expected.", sb.outstanding());
    $display("** stream_substring_replace: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
hdl/ssr_pkg.sv
hdl/ssr_if.sv
hdl/ssr_cfg.sv
hdl/ssr_front.sv
hdl/ssr_back.sv
hdl/stream_substring_replace.sv
sim/ssr_tb_pkg.sv
sim/testbench.sv
